### hdl/euler_path_finder_defines.svh
// assertion macros used by the euler path finder top level
`ifndef EULER_PATH_FINDER_DEFINES_SVH
`define EULER_PATH_FINDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define EPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/epf_pkg.sv
// package: types, constants and codes of the euler path finder
package epf_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 63;
	localparam int VW           = 7;
	localparam int IDX_W        = 6;
	localparam int ROW_W        = MAX_VERTICES;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_SOLVE = 1'b1;

	typedef struct packed {
		logic          action;
		logic [VW-1:0] end_a;
		logic [VW-1:0] end_b;
	} in_item_t;

	typedef struct packed {
		logic [VW-1:0] vertex;
		logic          found;
		logic          last;
	} out_item_t;

	// request to the adjacency row store
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [ROW_W-1:0] wr_data;
		logic             clr_all;
	} adj_req_t;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_ADD_B   = 11'b00000000010,
		S_ADD_W   = 11'b00000000100,
		S_RD      = 11'b00000001000,
		S_FIND    = 11'b00000010000,
		S_CLR     = 11'b00000100000,
		S_POP     = 11'b00001000000,
		S_CHECK   = 11'b00010000000,
		S_EMIT_RD = 11'b00100000000,
		S_EMIT_WR = 11'b01000000000,
		S_FAIL    = 11'b10000000000
	} state_t;

	// vertex number (1..64) to row bit index
	function automatic logic [IDX_W-1:0] vidx(input logic [VW-1:0] v);
		logic [VW-1:0] t;
		t = v - VW'(1);
		return t[IDX_W-1:0];
	endfunction
endpackage

### hdl/epf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module epf_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

### hdl/epf_adj_ram.sv
// adjacency row store: one 64-bit row per vertex, with per-row valid flags
module epf_adj_ram
	import epf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  adj_req_t         req,
	output logic [ROW_W-1:0] rdata
);
	logic [ROW_W-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] vld_q;
	logic [ROW_W-1:0] raw_q;
	logic             rvld_q;

	// row storage
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_q <= mem[req.rd_addr];
		end
	end

	// row valid flags, an invalid row reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rvld_q <= vld_q[req.rd_addr];
			end
			if (req.clr_all) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? raw_q : '0;
endmodule

### hdl/euler_path_finder.sv
// top level: edge loading, hierholzer walk sequencer and path output
//
//  channel | signals                   | carries
//  in      | in_valid in_ready in_data | edge add or solve request
//  out     | out_valid out_ready out_data | path vertex, found, last
//  cfg     | cfg_valid cfg_ready cfg_data | vertex_count, always ready
//
// edge add: read/modify/write of both adjacency rows through the idle, add_b and add_w states;
//   a rejected edge only sets the error flag. solve: each edge walked passes rd, find and clr,
//   each vertex popped rd, find and pop (the last rd and find), then check, then emit_rd and emit_wr per result.
// a failed solve loads its single result in the fail state that follows the check, once the output is free.
// reset clears all row valid flags at once; no clearing pass is needed.
// a stalled output holds the sequencer; one result waits in the output register.
module euler_path_finder
	import epf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_item_t      in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_item_t     out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [VW-1:0] cfg_data
);
	`include "euler_path_finder_defines.svh"

	state_t st_q, st_d;
	logic [VW-1:0]           vc_q, n_eff;
	logic [ROW_W-1:0]        par_q, mask, row, masked, lowest;
	logic [VW-1:0]           edge_cnt_q, odd_q, plen_q, depth_q;
	logic                    err_q;
	logic [VW-1:0]           a_q, b_q, u_q, next_q, nxt;
	logic [IDX_W-1:0]        idx_q, nxt_i;
	logic                    out_free, in_acc, a_ok, b_ok, ok;
	adj_req_t                areq;
	logic [VW-1:0]           stk_rdata, path_rdata;
	logic                    stk_we, stk_re, path_we, path_re;
	logic [IDX_W-1:0]        stk_raddr;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;

	// effective vertex count and row mask
	assign n_eff = (vc_q > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vc_q;
	always_comb begin
		for (int i = 0; i < ROW_W; i++) begin
			mask[i] = (VW'(i) < n_eff);
		end
	end

	assign a_ok = (in_data.end_a != '0) && (in_data.end_a <= n_eff);
	assign b_ok = (in_data.end_b != '0) && (in_data.end_b <= n_eff);

	// smallest unused neighbour of the current vertex
	assign masked = row & mask;
	assign lowest = masked & (~masked + ROW_W'(1));
	always_comb begin
		nxt_i = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (lowest[i]) nxt_i = nxt_i | IDX_W'(i);
		end
		nxt = VW'(nxt_i) + VW'(1);
	end

	assign ok = (plen_q == edge_cnt_q + VW'(1)) &&
		((odd_q == '0) || ((odd_q == VW'(2)) && par_q[0]));

	// adjacency, stack and path requests
	always_comb begin
		areq      = '0;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_raddr = vidx(depth_q);
		path_we   = 1'b0;
		path_re   = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				areq.rd_en   = in_acc && (in_data.action == ACT_ADD);
				areq.rd_addr = vidx(in_data.end_a);
			end
			S_ADD_B: begin
				areq.wr_en   = 1'b1;
				areq.wr_addr = vidx(a_q);
				areq.wr_data = row | (ROW_W'(1) << vidx(b_q));
				areq.rd_en   = 1'b1;
				areq.rd_addr = vidx(b_q);
			end
			S_ADD_W: begin
				areq.wr_en   = 1'b1;
				areq.wr_addr = vidx(b_q);
				areq.wr_data = row | (ROW_W'(1) << vidx(a_q));
			end
			S_RD: begin
				areq.rd_en   = 1'b1;
				areq.rd_addr = vidx(u_q);
			end
			S_FIND: begin
				if (masked != '0) begin
					areq.wr_en   = 1'b1;
					areq.wr_addr = vidx(u_q);
					areq.wr_data = row & ~(ROW_W'(1) << nxt_i);
					areq.rd_en   = 1'b1;
					areq.rd_addr = nxt_i;
				end else begin
					path_we = 1'b1;
					stk_re  = (depth_q != '0);
				end
			end
			S_CLR: begin
				areq.wr_en   = 1'b1;
				areq.wr_addr = vidx(next_q);
				areq.wr_data = row & ~(ROW_W'(1) << vidx(u_q));
				stk_we       = 1'b1;
			end
			S_CHECK: areq.clr_all = 1'b1;
			S_EMIT_RD: path_re = 1'b1;
			default: ;
		endcase
	end

	epf_adj_ram u_adj (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rdata  (row)
	);

	epf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_stack (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (depth_q[IDX_W-1:0]),
		.wr_data (u_q),
		.rd_en   (stk_re),
		.rd_addr (stk_raddr),
		.rd_data (stk_rdata)
	);

	epf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_path (
		.clk     (clk),
		.wr_en   (path_we),
		.wr_addr (plen_q[IDX_W-1:0]),
		.wr_data (u_q),
		.rd_en   (path_re),
		.rd_addr (idx_q),
		.rd_data (path_rdata)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (in_acc && (in_data.action == ACT_SOLVE)) begin
					st_d = (err_q || (n_eff == '0)) ? S_CHECK : S_RD;
				end else if (in_acc && a_ok && b_ok && (edge_cnt_q < VW'(MAX_EDGES))) begin
					st_d = S_ADD_B;
				end
			end
			S_ADD_B:   st_d = S_ADD_W;
			S_ADD_W:   st_d = S_IDLE;
			S_RD:      st_d = S_FIND;
			S_FIND: begin
				if (masked != '0)        st_d = S_CLR;
				else if (depth_q != '0)  st_d = S_POP;
				else                     st_d = S_CHECK;
			end
			S_CLR:     st_d = S_RD;
			S_POP:     st_d = S_RD;
			S_CHECK:   st_d = (ok && !err_q && (n_eff != '0)) ? S_EMIT_RD : S_FAIL;
			S_EMIT_RD: st_d = S_EMIT_WR;
			S_EMIT_WR: begin
				if (out_free) st_d = (idx_q == '0) ? S_IDLE : S_EMIT_RD;
			end
			S_FAIL: begin
				if (out_free) st_d = S_IDLE;
			end
			default:   st_d = S_IDLE;
		endcase
	end

	// control and store registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			vc_q       <= VW'(MAX_VERTICES);
			par_q      <= '0;
			edge_cnt_q <= '0;
			odd_q      <= '0;
			err_q      <= 1'b0;
			plen_q     <= '0;
			depth_q    <= '0;
			out_valid  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) vc_q <= cfg_data;
			// output valid: set when a result is loaded, cleared when taken
			if (((st_q == S_EMIT_WR) || (st_q == S_FAIL)) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_acc && (in_data.action == ACT_SOLVE)) begin
						plen_q  <= '0;
						depth_q <= '0;
					end else if (in_acc) begin
						if (a_ok && b_ok && (edge_cnt_q < VW'(MAX_EDGES))) begin
							edge_cnt_q <= edge_cnt_q + VW'(1);
							par_q <= par_q ^ (ROW_W'(1) << vidx(in_data.end_a))
								^ (ROW_W'(1) << vidx(in_data.end_b));
							if (in_data.end_a != in_data.end_b) begin
								odd_q <= odd_q
									+ (par_q[vidx(in_data.end_a)] ? ~VW'(0) : VW'(1))
									+ (par_q[vidx(in_data.end_b)] ? ~VW'(0) : VW'(1));
							end
						end else begin
							err_q <= 1'b1;
						end
					end
				end
				S_FIND: begin
					if (masked == '0) plen_q <= plen_q + VW'(1);
				end
				S_CLR:  depth_q <= depth_q + VW'(1);
				S_POP:  depth_q <= depth_q - VW'(1);
				S_CHECK: begin
					par_q      <= '0;
					edge_cnt_q <= '0;
					odd_q      <= '0;
					err_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// walk and output payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q <= in_data.end_a;
			b_q <= in_data.end_b;
			u_q <= VW'(1);
		end
		if ((st_q == S_FIND) && (masked != '0)) next_q <= nxt;
		if (st_q == S_CLR) u_q <= next_q;
		if (st_q == S_POP) u_q <= stk_rdata;
		if (st_q == S_CHECK) idx_q <= IDX_W'(plen_q - VW'(1));
		if ((st_q == S_EMIT_WR) && out_free) begin
			out_data.vertex <= path_rdata;
			out_data.found  <= 1'b1;
			out_data.last   <= (idx_q == '0);
			idx_q           <= idx_q - IDX_W'(1);
		end
		if ((st_q == S_FAIL) && out_free) begin
			out_data.vertex <= '0;
			out_data.found  <= 1'b0;
			out_data.last   <= 1'b1;
		end
	end

	`EPF_ASSERT_NOW(a_stack_room, (st_q == S_CLR), (depth_q < VW'(MAX_VERTICES)),
		"walk stack overflow")
	`EPF_ASSERT_NOW(a_path_len, 1'b1, (plen_q <= VW'(MAX_VERTICES)),
		"path longer than the buffer")
	`EPF_ASSERT_NEXT(a_cleared, (st_q == S_CHECK), ((edge_cnt_q == '0) && !err_q),
		"stores not cleared after solve")
	`EPF_ASSERT_NOW(a_idle_empty, (st_q == S_IDLE), (depth_q == '0),
		"walk stack not empty when idle")
endmodule

### bench/euler_path_finder_tb.sv
// testbench for euler_path_finder: random graphs, shadow predictor, in-order result check
module euler_path_finder_tb;
	import epf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int STACK_DEPTH    = MAX_EDGES + 2;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	in_item_t      in_data;
	logic          out_valid;
	logic          out_ready;
	out_item_t     out_data;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [VW-1:0] cfg_data;

	// shadow copy of the graph stores
	logic [MAX_VERTICES:0] adj_mx  [0:MAX_VERTICES];
	logic [MAX_VERTICES:0] walk_mx [0:MAX_VERTICES];
	logic [MAX_VERTICES:0] odd_deg;
	int                    edge_total;
	bit                    edge_err;
	int                    vcount;

	in_item_t  request_q[$];
	out_item_t path_expect_q[$];
	int        errors;
	int        results_seen;
	int        items_sent;

	// scratch for graph generation
	int                    trail_a [0:STACK_DEPTH];
	int                    trail_b [0:STACK_DEPTH];
	int                    trail_len;
	logic [MAX_VERTICES:0] trail_used [0:MAX_VERTICES];

	euler_path_finder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic int eff_vertices();
		return (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
	endfunction

	task automatic clear_graph();
		for (int i = 0; i <= MAX_VERTICES; i++) begin
			adj_mx[i]  = '0;
			walk_mx[i] = '0;
		end
		odd_deg    = '0;
		edge_total = 0;
		edge_err   = 1'b0;
	endtask

	// append one expected result at the tail
	task automatic add_expect(input out_item_t r);
		path_expect_q.insert(path_expect_q.size(), r);
	endtask

	task automatic load_edge(input int a, input int b);
		int n;
		n = eff_vertices();
		if (a < 1 || a > n || b < 1 || b > n || edge_total >= MAX_EDGES) begin
			edge_err = 1'b1;
			return;
		end
		adj_mx[a][b] = 1'b1;
		adj_mx[b][a] = 1'b1;
		odd_deg[a]   = ~odd_deg[a];
		odd_deg[b]   = ~odd_deg[b];
		edge_total++;
	endtask

	// hierholzer walk from vertex 1, smallest unused neighbor first
	task automatic solve_graph();
		int        n;
		int        sp;
		int        plen;
		int        odd;
		int        u;
		int        nxt;
		bit        ok;
		int        stk  [0:STACK_DEPTH];
		int        path [0:STACK_DEPTH];
		out_item_t r;
		n    = eff_vertices();
		sp   = 0;
		plen = 0;
		odd  = 0;
		ok   = !edge_err && n >= 1;
		if (ok) begin
			stk[sp++] = 1;
			while (sp > 0) begin
				u   = stk[sp-1];
				nxt = 0;
				for (int v = 1; v <= n; v++) begin
					if (adj_mx[u][v] && !walk_mx[u][v]) begin
						nxt = v;
						break;
					end
				end
				if (nxt != 0 && sp < STACK_DEPTH) begin
					walk_mx[u][nxt] = 1'b1;
					walk_mx[nxt][u] = 1'b1;
					stk[sp++] = nxt;
				end else begin
					if (plen < STACK_DEPTH) path[plen++] = u;
					sp--;
				end
			end
			for (int v = 1; v <= n; v++)
				if (odd_deg[v]) odd++;
			ok = (plen == edge_total + 1) && (odd == 0 || (odd == 2 && odd_deg[1]));
			if (plen > MAX_VERTICES) ok = 1'b0;
		end
		clear_graph();
		if (!ok) begin
			r.vertex = '0;
			r.found  = 1'b0;
			r.last   = 1'b1;
			add_expect(r);
		end else begin
			for (int i = 0; i < plen; i++) begin
				r.vertex = VW'(path[plen-1-i]);
				r.found  = 1'b1;
				r.last   = (i + 1 == plen);
				add_expect(r);
			end
		end
	endtask

	// request driver
	int gap_left;
	bit no_gap_run;
	always @(posedge clk or negedge arst_n) begin
		logic     nv;
		in_item_t nd;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= '0;
			gap_left   <= 0;
			no_gap_run <= 1'b0;
		end else begin
			nv = in_valid;
			nd = in_data;
			if (in_valid && in_ready) begin
				if (in_data.action == ACT_ADD) load_edge(in_data.end_a, in_data.end_b);
				else begin
					solve_graph();
					no_gap_run <= ($urandom_range(0, 3) == 0);
				end
				nv       = 1'b0;
				gap_left <= no_gap_run ? 0 : pick_gap();
			end else if (!in_valid && gap_left > 0) begin
				gap_left <= gap_left - 1;
			end
			if (!nv && (gap_left == 0 || (in_valid && in_ready && no_gap_run))
					&& request_q.size() > 0) begin
				nd = request_q.pop_front();
				nv = 1'b1;
			end
			in_valid <= nv;
			in_data  <= nd;
		end
	end

	// result monitor with random backpressure and one long hold
	int  hold_left;
	bit  long_hold_done;
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			out_ready      <= 1'b0;
			hold_left      <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (path_expect_q.size() == 0) begin
					$error("unexpected result vertex=%0d found=%0d last=%0d",
						out_data.vertex, out_data.found, out_data.last);
					errors++;
				end else begin
					exp_r = path_expect_q.pop_front();
					if (out_data.vertex !== exp_r.vertex) begin
						$error("vertex expected %0d got %0d", exp_r.vertex, out_data.vertex);
						errors++;
					end
					if (out_data.found !== exp_r.found) begin
						$error("found expected %0d got %0d", exp_r.found, out_data.found);
						errors++;
					end
					if (out_data.last !== exp_r.last) begin
						$error("last expected %0d got %0d", exp_r.last, out_data.last);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 150) begin
				long_hold_done <= 1'b1;
				hold_left      <= 400;
				out_ready      <= 1'b0;
			end else if (out_ready && out_valid) begin
				hold_left <= no_gap_run ? 0 : pick_gap();
				out_ready <= no_gap_run || ($urandom_range(0, 2) != 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any accepted request, result or write
	int idle_cycles;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic push_req(input logic act, input int a, input int b);
		in_item_t it;
		it.action = act;
		it.end_a  = VW'(a);
		it.end_b  = VW'(b);
		request_q.insert(request_q.size(), it);
		items_sent++;
	endtask

	task automatic push_edge(input int a, input int b);
		push_req(ACT_ADD, a, b);
	endtask

	task automatic push_solve();
		push_req(ACT_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127));
	endtask

	task automatic drain();
		while (request_q.size() > 0 || in_valid || path_expect_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_vcount(input int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= VW'(v);
		do @(posedge clk); while (!cfg_ready);
		vcount = v & 8'h7f;
		cfg_valid <= 1'b0;
	endtask

	// random trail from vertex 1 over vertices 1..n, then loaded in shuffled order
	task automatic gen_trail(input int n, input int len);
		int cur;
		int v;
		int j;
		int t;
		bit got;
		for (int i = 0; i <= MAX_VERTICES; i++) trail_used[i] = '0;
		cur       = 1;
		trail_len = 0;
		for (int k = 0; k < len && trail_len < MAX_EDGES; k++) begin
			got = 1'b0;
			for (int tr = 0; tr < 16 && !got; tr++) begin
				v = $urandom_range(1, n);
				if (!trail_used[cur][v]) got = 1'b1;
			end
			if (!got) break;
			trail_used[cur][v] = 1'b1;
			trail_used[v][cur] = 1'b1;
			trail_a[trail_len] = cur;
			trail_b[trail_len] = v;
			trail_len++;
			cur = v;
		end
		for (int i = trail_len - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = trail_a[i]; trail_a[i] = trail_a[j]; trail_a[j] = t;
			t = trail_b[i]; trail_b[i] = trail_b[j]; trail_b[j] = t;
		end
	endtask

	// one graph: mostly a clean trail, sometimes damaged
	task automatic random_graph(input int n, input int len);
		int kind;
		int k;
		gen_trail(n, len);
		kind = $urandom_range(0, 9);
		k    = (trail_len > 0) ? $urandom_range(0, trail_len - 1) : 0;
		for (int i = 0; i < trail_len; i++) begin
			// damaged variant drops one edge
			if (kind == 7 && i == k) continue;
			if ($urandom_range(0, 1)) push_edge(trail_a[i], trail_b[i]);
			else push_edge(trail_b[i], trail_a[i]);
			// parallel copy
			if (kind == 8 && i == k) push_edge(trail_a[i], trail_b[i]);
		end
		// junk endpoint anywhere in the field range
		if (kind == 9) push_edge($urandom_range(0, 127), $urandom_range(0, 127));
		push_solve();
	endtask

	int n_eff;
	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		errors       = 0;
		results_seen = 0;
		items_sent   = 0;
		vcount       = MAX_VERTICES;
		clear_graph();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases at the reset vertex count
		push_solve();
		push_edge(1, 64);  push_solve();
		push_edge(0, 1);   push_solve();
		push_edge(1, 65);  push_solve();
		push_edge(127, 127); push_solve();
		push_edge(1, 1);   push_solve();
		push_edge(1, 2);   push_edge(2, 1); push_solve();
		push_edge(1, 2);   push_edge(2, 3); push_edge(3, 1); push_solve();
		push_edge(2, 3);   push_solve();
		push_edge(2, 3);   push_edge(3, 4); push_edge(4, 2); push_solve();
		drain();

		// zero vertices rejects every edge
		write_vcount(0);
		push_solve();
		push_edge(1, 1); push_solve();
		drain();
		// above the maximum acts as the maximum
		write_vcount(127);
		push_edge(64, 1); push_solve();
		drain();
		write_vcount(1);
		push_solve();
		push_edge(1, 1); push_solve();
		push_edge(1, 2); push_solve();
		drain();

		// longest path, then edge overflow
		write_vcount(64);
		gen_trail(64, 63);
		for (int i = 0; i < trail_len; i++) push_edge(trail_a[i], trail_b[i]);
		push_solve();
		for (int i = 0; i < MAX_EDGES; i++) push_edge(1, 1 + (i % 2));
		push_edge(1, 2);
		push_solve();
		drain();

		// random phases, each with its own vertex count
		while (items_sent < 370) begin
			case ($urandom_range(0, 5))
				0:       write_vcount(64);
				1:       write_vcount(2);
				2:       write_vcount($urandom_range(65, 127));
				default: write_vcount($urandom_range(3, 12));
			endcase
			n_eff = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
			for (int g = 0; g < 6; g++) begin
				if ($urandom_range(0, 9) == 0) random_graph(n_eff, $urandom_range(20, 63));
				else random_graph(n_eff, $urandom_range(0, 8));
			end
			drain();
		end

		drain();
		if (errors == 0 && path_expect_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

### sim.f
+incdir+hdl
hdl/epf_pkg.sv
hdl/epf_ram.sv
hdl/epf_adj_ram.sv
hdl/euler_path_finder.sv
bench/euler_path_finder_tb.sv
